/* rtl/iws_pkg.sv */
// shared types and constants for the identifier word splitter
`default_nettype none

package iws_pkg;

  localparam int CHAR_W   = 8;
  localparam int START_W  = 8;
  localparam int LENGTH_W = 9;
  localparam int STATUS_W = 2;

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UNDER   = 8'h5F;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

  typedef enum logic [1:0] {
    CLASS_IDLE,
    CLASS_DIGIT,
    CLASS_WORD,
    CLASS_CAPS
  } run_class_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_BUSY,
    STATUS_ACCEPTED,
    STATUS_REJECTED
  } split_status_t;

  typedef struct packed {
    logic [CHAR_W-1:0] lowered;
    logic              is_upper;
    logic              is_lower;
    logic              is_digit;
    logic              is_under;
  } char_info_t;

endpackage

`default_nettype wire

/* rtl/iws_in_if.sv */
// input channel: one identifier character per word
`default_nettype none

interface iws_in_if import iws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              final_char;

  modport source (output valid, char_code, final_char, input ready);
  modport sink   (input valid, char_code, final_char, output ready);
endinterface

`default_nettype wire

/* rtl/iws_out_if.sv */
// result channel: lowered character plus completed word info
`default_nettype none

interface iws_out_if import iws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHAR_W-1:0]   lowered_char;
  logic                word_found;
  logic [START_W-1:0]  word_start;
  logic [LENGTH_W-1:0] word_length;
  logic [STATUS_W-1:0] split_status;

  modport source (output valid, lowered_char, word_found, word_start, word_length,
                  split_status, input ready);
  modport sink   (input valid, lowered_char, word_found, word_start, word_length,
                  split_status, output ready);
endinterface

`default_nettype wire

/* rtl/iws_char_class.sv */
// character classifier and ascii lower-casing
`default_nettype none

module iws_char_class import iws_pkg::*; (
  input  wire logic [CHAR_W-1:0] char_code,
  output char_info_t             info
);

  always_comb begin
    info.is_upper = char_code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
    info.is_lower = char_code inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
    info.is_digit = char_code inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]};
    info.is_under = (char_code == CHAR_UNDER);
    info.lowered  = info.is_upper ? char_code + CASE_OFFSET : char_code;
  end

endmodule

`default_nettype wire

/* rtl/identifier_word_splitter_top.sv */
// top level of the identifier word splitter
`default_nettype none

// Splits an identifier, streamed one character per word, into words for a
// spell checker. A word is a run of lower-case letters, optionally led by one
// capital; in a capital run followed by a lower-case letter the last capital
// starts the word, other capital runs and digit runs are dropped, underscores
// separate words. Every input word yields exactly one result word: the
// character lower-cased, and on the character that ends a word its start
// position and length (a word still open at final_char is reported on that
// character, inclusive). Any character outside letters, digits and underscore,
// or an identifier longer than MAX_LEN, rejects the identifier: no more words
// are flagged and the final character reports status rejected. The final
// character always returns the scanner to its reset state. Throughput is one
// word per clock, an item entering every cycle, unless out_ch.ready stalls the
// result register; the only loop is the scanner state update between the input
// stage and the result register, which every character passes through in turn.
// Positions wrap to 8 bits in word_start and lengths to 9 bits in word_length.

module identifier_word_splitter_top import iws_pkg::*; #(
  parameter int MAX_LEN = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  iws_in_if.sink    in_ch,
  iws_out_if.source out_ch
);

  // position counter saturates at MAX_LEN, so it needs room for MAX_LEN itself
  localparam int POS_W = $clog2(MAX_LEN + 1);
  // working width for start/length math, at least as wide as the length field
  localparam int EXT_W = (POS_W > LENGTH_W) ? POS_W : LENGTH_W;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

  // input stage
  logic              stage_v_r;
  logic [CHAR_W-1:0] stage_code_r;
  logic              stage_last_r;

  // scanner state
  run_class_t       class_r, class_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]       cap_r, cap_nxt;
  logic             rej_r, rej_nxt;

  // result register
  logic                out_v_r;
  logic [CHAR_W-1:0]   lowered_r;
  logic                found_r, found_nxt;
  logic [START_W-1:0]  wstart_r, wstart_nxt;
  logic [LENGTH_W-1:0] wlen_r, wlen_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  char_info_t info;
  logic       out_free;
  logic       advance;
  logic       in_take;
  logic       bad_char;
  logic       rej_now;
  logic [EXT_W-1:0] pos_ext;
  logic [EXT_W-1:0] len_ext;

  iws_char_class u_class (
    .char_code (stage_code_r),
    .info      (info)
  );

  // result slot frees when empty or being drained; the input stage moves on then
  assign out_free    = !out_v_r || out_ch.ready;
  assign advance     = stage_v_r && out_free;
  assign in_ch.ready = !stage_v_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign bad_char = !(info.is_upper || info.is_lower || info.is_digit || info.is_under);
  assign rej_now  = rej_r || bad_char || (pos_r >= MAX_POS);
  assign pos_ext  = EXT_W'(pos_r);

  always_comb begin
    class_nxt  = class_r;
    start_nxt  = start_r;
    cap_nxt    = cap_r;
    rej_nxt    = rej_now;
    pos_nxt    = (pos_r < MAX_POS) ? pos_r + POS_W'(1) : pos_r;
    found_nxt  = 1'b0;
    len_ext    = '0;
    wstart_nxt = '0;
    status_nxt = STATUS_BUSY;

    if (!rej_now) begin
      // a word run ends on any character that is not lower case
      if (class_r == CLASS_WORD && !info.is_lower) begin
        found_nxt  = 1'b1;
        wstart_nxt = START_W'(start_r);
        len_ext    = pos_ext - EXT_W'(start_r);
      end

      if (info.is_under) begin
        class_nxt = CLASS_IDLE;
        cap_nxt   = 2'd0;
      end else if (info.is_digit) begin
        class_nxt = CLASS_DIGIT;
        cap_nxt   = 2'd0;
      end else if (info.is_upper) begin
        if (class_r == CLASS_CAPS) begin
          if (cap_r != 2'd3) begin
            cap_nxt = cap_r + 2'd1;
          end
        end else begin
          class_nxt = CLASS_CAPS;
          cap_nxt   = 2'd1;
        end
        // remember the latest capital, it may lead the next word
        start_nxt = pos_r;
      end else begin
        if (class_r == CLASS_IDLE || class_r == CLASS_DIGIT) begin
          start_nxt = pos_r;
        end
        class_nxt = CLASS_WORD;
        cap_nxt   = 2'd0;
      end

      // word still open on the last character closes inclusive of it
      if (stage_last_r && class_nxt == CLASS_WORD) begin
        found_nxt  = 1'b1;
        wstart_nxt = START_W'(start_nxt);
        len_ext    = pos_ext + EXT_W'(1) - EXT_W'(start_nxt);
      end
    end

    wlen_nxt = len_ext[LENGTH_W-1:0];

    // end of identifier: report and start over
    if (stage_last_r) begin
      status_nxt = rej_now ? STATUS_REJECTED : STATUS_ACCEPTED;
      class_nxt  = CLASS_IDLE;
      start_nxt  = '0;
      pos_nxt    = '0;
      cap_nxt    = 2'd0;
      rej_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      out_v_r   <= 1'b0;
      class_r   <= CLASS_IDLE;
      start_r   <= '0;
      pos_r     <= '0;
      cap_r     <= 2'd0;
      rej_r     <= 1'b0;
    end else begin
      if (in_take) begin
        stage_v_r <= 1'b1;
      end else if (advance) begin
        stage_v_r <= 1'b0;
      end

      if (advance) begin
        out_v_r <= 1'b1;
        class_r <= class_nxt;
        start_r <= start_nxt;
        pos_r   <= pos_nxt;
        cap_r   <= cap_nxt;
        rej_r   <= rej_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end

    // payload, no reset needed
    if (in_take) begin
      stage_code_r <= in_ch.char_code;
      stage_last_r <= in_ch.final_char;
    end
    if (advance) begin
      lowered_r <= info.lowered;
      found_r   <= found_nxt;
      wstart_r  <= wstart_nxt;
      wlen_r    <= wlen_nxt;
      status_r  <= status_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.lowered_char = lowered_r;
  assign out_ch.word_found   = found_r;
  assign out_ch.word_start   = wstart_r;
  assign out_ch.word_length  = wlen_r;
  assign out_ch.split_status = status_r;

  // a flagged word never comes with a rejected identifier
  a_found_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && found_r |-> status_r != STATUS_REJECTED)
    else $error("word flagged on rejected identifier");

  // no word means zeroed start and length
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !found_r |-> wstart_r == '0 && wlen_r == '0)
    else $error("word fields set without a word");

  // the final character leaves the scanner in its reset state
  a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stage_last_r |=> pos_r == '0 && !rej_r && class_r == CLASS_IDLE)
    else $error("scanner not reset after final character");

endmodule

`default_nettype wire
